/* rtl/damaged_media_read_scheduler_macros.svh */
// assertion macros shared by the scheduler modules
`ifndef DAMAGED_MEDIA_READ_SCHEDULER_MACROS_SVH
`define DAMAGED_MEDIA_READ_SCHEDULER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DMRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define DMRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dmrs_pkg.sv */
// types and constants of the damaged media read scheduler
`timescale 1ns / 1ps
package dmrs_pkg;

    localparam int LBA_W           = 48;
    localparam int SECS_W          = 9;
    localparam int ZONES_OUT_W     = 11;
    localparam int CFG_IDX_W       = 2;
    localparam int CHUNK_SECTORS   = 256;
    localparam int SPLIT_ZONE_CAP  = 1000;
    localparam logic [LBA_W-1:0] SPLIT_MIN_RESET = 48'd1000000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LBA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LBA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_MIN  = 2'd2;

    // request opcodes
    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_REPORT  = 2'd1,
        OP_RESTART = 2'd2,
        OP_UNUSED  = 2'd3
    } opcode_t;

    // datapath commands
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_RESTART,
        CMD_REQ_EMPTY,
        CMD_RES_ZERO,
        CMD_WALK_START,
        CMD_WALK_NEXT,
        CMD_CAPTURE,
        CMD_TAKE,
        CMD_TAKE_FWD,
        CMD_HEAD_READ,
        CMD_SPLIT_MID,
        CMD_SPLIT_NEW,
        CMD_SPLIT_HEAD,
        CMD_REP_READ,
        CMD_REP_UPDATE,
        CMD_PREV_READ,
        CMD_UNLINK_PREV,
        CMD_UNLINK_HEAD,
        CMD_POST
    } dp_cmd_t;

    // datapath status toward the controller
    typedef struct packed {
        logic count_zero;
        logic walk_good;
        logic walk_last;
        logic split_ok;
        logic zone_empty;
        logic has_prev;
        logic pending;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/dmrs_if.sv */
// request and result channel interfaces
`timescale 1ns / 1ps
interface dmrs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       read_error;

    modport source (output valid, output opcode, output read_error, input ready);
    modport sink   (input valid, input opcode, input read_error, output ready);
endinterface

interface dmrs_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] task_lba;
    logic [8:0]  task_sectors;
    logic        all_done;
    logic [10:0] zones_in_use;

    modport source (output valid, output task_lba, output task_sectors,
                    output all_done, output zones_in_use, input ready);
    modport sink   (input valid, input task_lba, input task_sectors,
                    input all_done, input zones_in_use, output ready);
endinterface

/* rtl/dmrs_ctrl.sv */
// controller state machine of the read scheduler
`timescale 1ns / 1ps
`include "damaged_media_read_scheduler_macros.svh"
module dmrs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_opcode,
    output logic                in_ready,
    input  dmrs_pkg::dp_status_t status,
    output dmrs_pkg::dp_cmd_t   cmd
);
    import dmrs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_TAKE,
        S_HEAD_WAIT,
        S_SPLIT_MID,
        S_SPLIT_CHK,
        S_SPLIT_HEAD,
        S_REP_WAIT,
        S_REP_UPD,
        S_REP_CHK,
        S_PREV_WAIT,
        S_ZERO,
        S_POST
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode_t'(in_opcode))
                        OP_REQUEST:
                        begin
                            if (status.count_zero)
                            begin
                                cmd        = CMD_REQ_EMPTY;
                                state_next = S_POST;
                            end
                            else
                            begin
                                cmd        = CMD_WALK_START;
                                state_next = S_WALK;
                            end
                        end
                        OP_REPORT:
                        begin
                            if (status.pending)
                            begin
                                cmd        = CMD_REP_READ;
                                state_next = S_REP_WAIT;
                            end
                            else
                            begin
                                state_next = S_ZERO;
                            end
                        end
                        OP_RESTART:
                        begin
                            cmd        = CMD_RESTART;
                            state_next = S_ZERO;
                        end
                        default:
                        begin
                            state_next = S_ZERO;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (status.walk_good)
                begin
                    cmd        = CMD_CAPTURE;
                    state_next = S_TAKE;
                end
                else if (status.walk_last)
                begin
                    cmd        = CMD_HEAD_READ;
                    state_next = S_HEAD_WAIT;
                end
                else
                begin
                    cmd = CMD_WALK_NEXT;
                end
            end
            S_TAKE:
            begin
                cmd        = CMD_TAKE;
                state_next = S_POST;
            end
            S_HEAD_WAIT:
            begin
                cmd        = CMD_CAPTURE;
                state_next = S_SPLIT_MID;
            end
            S_SPLIT_MID:
            begin
                cmd        = CMD_SPLIT_MID;
                state_next = S_SPLIT_CHK;
            end
            S_SPLIT_CHK:
            begin
                if (status.split_ok)
                begin
                    cmd        = CMD_SPLIT_NEW;
                    state_next = S_SPLIT_HEAD;
                end
                else
                begin
                    cmd        = CMD_TAKE_FWD;
                    state_next = S_POST;
                end
            end
            S_SPLIT_HEAD:
            begin
                cmd        = CMD_SPLIT_HEAD;
                state_next = S_TAKE;
            end
            S_REP_WAIT:
            begin
                cmd        = CMD_CAPTURE;
                state_next = S_REP_UPD;
            end
            S_REP_UPD:
            begin
                cmd        = CMD_REP_UPDATE;
                state_next = S_REP_CHK;
            end
            S_REP_CHK:
            begin
                if (!status.zone_empty)
                begin
                    state_next = S_ZERO;
                end
                else if (status.has_prev)
                begin
                    cmd        = CMD_PREV_READ;
                    state_next = S_PREV_WAIT;
                end
                else
                begin
                    cmd        = CMD_UNLINK_HEAD;
                    state_next = S_ZERO;
                end
            end
            S_PREV_WAIT:
            begin
                cmd        = CMD_UNLINK_PREV;
                state_next = S_ZERO;
            end
            S_ZERO:
            begin
                cmd        = CMD_RES_ZERO;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (status.out_free)
                begin
                    cmd        = CMD_POST;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `DMRS_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "accepted while busy")
    `DMRS_ASSERT_NEXT(a_post_to_idle, state_reg == S_POST && status.out_free, in_ready,
        "result posted but controller not idle")
    `DMRS_ASSERT_NOW(a_walk_nonempty, state_reg == S_WALK, !status.count_zero,
        "zone walk on empty table")

endmodule

/* rtl/dmrs_datapath.sv */
// zone table, free slot stack and arithmetic of the read scheduler
`timescale 1ns / 1ps
`include "damaged_media_read_scheduler_macros.svh"
module dmrs_datapath #(
    parameter int MAX_ZONES = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dmrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmrs_pkg::LBA_W-1:0]      cfg_data,
    input  logic                            accept,
    input  logic                            read_error,
    input  dmrs_pkg::dp_cmd_t               cmd,
    output dmrs_pkg::dp_status_t            status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dmrs_pkg::LBA_W-1:0]      out_lba,
    output logic [dmrs_pkg::SECS_W-1:0]     out_secs,
    output logic                            out_done,
    output logic [dmrs_pkg::ZONES_OUT_W-1:0] out_zones
);
    import dmrs_pkg::*;

    localparam int AW = $clog2(MAX_ZONES);
    localparam int CW = $clog2(MAX_ZONES + 1);

    typedef struct packed {
        logic [LBA_W-1:0] zbegin;
        logic [LBA_W-1:0] zend;
        logic             bb;
        logic             eb;
        logic [AW-1:0]    znext;
    } zone_t;

    // zone table and free slot stack
    zone_t         zmem [MAX_ZONES];
    logic [AW-1:0] fstack [MAX_ZONES];

    logic [LBA_W-1:0]  first_reg, limit_reg, smin_reg;
    logic [AW-1:0]     head_reg, cur_reg, prev_reg, curidx_reg, curprev_reg, nz_reg;
    logic              has_prev_reg, curhas_prev_reg, back_reg, pend_reg, failed_reg;
    logic [CW-1:0]     count_reg, n_reg, sp_reg, hwm_reg;
    logic [SECS_W-1:0] tlen_reg, res_secs_reg;
    logic [LBA_W-1:0]  res_lba_reg, len_reg, mid_reg;
    zone_t             rec_reg, rd_rec;
    logic [AW-1:0]     stk_top_reg;
    logic              ov_reg;
    logic [LBA_W-1:0]  ol_reg;
    logic [SECS_W-1:0] os_reg;
    logic              od_reg;
    logic [ZONES_OUT_W-1:0] oz_reg;

    logic [AW-1:0]     rd_addr;
    logic              we;
    logic [AW-1:0]     waddr;
    zone_t             wdata;
    logic [LBA_W-1:0]  rd_len;
    logic [SECS_W-1:0] secs;
    logic [SECS_W-1:0] tl;
    zone_t             upd_rec;
    logic              push;
    logic [AW-1:0]     alloc_slot;

    // length of the record just read
    assign rd_len = (rd_rec.zend > rd_rec.zbegin) ? rd_rec.zend - rd_rec.zbegin : '0;

    // chunk of the captured zone
    assign secs = (len_reg < LBA_W'(CHUNK_SECTORS)) ? len_reg[SECS_W-1:0]
                                                    : SECS_W'(CHUNK_SECTORS);

    // shrink of the reported zone
    assign tl = (len_reg < LBA_W'(tlen_reg)) ? len_reg[SECS_W-1:0] : tlen_reg;

    always_comb
    begin
        upd_rec = rec_reg;
        if (rec_reg.bb && rec_reg.eb)
        begin
            upd_rec.zbegin = rec_reg.zbegin + LBA_W'(tl);
        end
        else if (!rec_reg.bb)
        begin
            upd_rec.zbegin = rec_reg.zbegin + LBA_W'(tl);
            upd_rec.bb     = failed_reg;
        end
        else
        begin
            upd_rec.zend = rec_reg.zend - LBA_W'(tl);
            upd_rec.eb   = failed_reg;
        end
    end

    assign alloc_slot = (sp_reg != '0) ? stk_top_reg : hwm_reg[AW-1:0];
    assign push       = (cmd == CMD_UNLINK_PREV) || (cmd == CMD_UNLINK_HEAD);

    // memory address and write selection
    always_comb
    begin
        rd_addr = cur_reg;
        we      = 1'b0;
        waddr   = '0;
        wdata   = rec_reg;
        case (cmd)
            CMD_WALK_START, CMD_HEAD_READ: rd_addr = head_reg;
            CMD_WALK_NEXT:                 rd_addr = rd_rec.znext;
            CMD_REP_READ:                  rd_addr = curidx_reg;
            CMD_PREV_READ:                 rd_addr = curprev_reg;
            CMD_RESTART:
            begin
                we    = 1'b1;
                waddr = '0;
                wdata = '{zbegin: first_reg, zend: limit_reg, bb: 1'b0, eb: 1'b0,
                          znext: '0};
            end
            CMD_SPLIT_NEW:
            begin
                we    = 1'b1;
                waddr = nz_reg;
                wdata = '{zbegin: mid_reg, zend: rec_reg.zend, bb: 1'b0,
                          eb: rec_reg.eb, znext: rec_reg.znext};
            end
            CMD_SPLIT_HEAD:
            begin
                we    = 1'b1;
                waddr = cur_reg;
                wdata = '{zbegin: rec_reg.zbegin, zend: mid_reg, bb: rec_reg.bb,
                          eb: 1'b0, znext: nz_reg};
            end
            CMD_REP_UPDATE:
            begin
                we    = 1'b1;
                waddr = curidx_reg;
                wdata = upd_rec;
            end
            CMD_UNLINK_PREV:
            begin
                we          = 1'b1;
                waddr       = curprev_reg;
                wdata       = rd_rec;
                wdata.znext = rec_reg.znext;
            end
            default:
            begin
                rd_addr = cur_reg;
            end
        endcase
    end

    // zone table ports
    always_ff @(posedge clk)
    begin
        if (we)
            zmem[waddr] <= wdata;
        rd_rec <= zmem[rd_addr];
    end

    // free slot stack ports
    always_ff @(posedge clk)
    begin
        if (push)
            fstack[sp_reg[AW-1:0]] <= curidx_reg;
        stk_top_reg <= fstack[AW'(sp_reg - 1'b1)];
    end

    // status toward the controller
    always_comb
    begin
        status.count_zero = (count_reg == '0);
        status.walk_good  = !rd_rec.bb || !rd_rec.eb;
        status.walk_last  = (CW'(n_reg + 1'b1) == count_reg);
        status.split_ok   = (len_reg > smin_reg)
                         && (32'(count_reg) < SPLIT_ZONE_CAP)
                         && (32'(count_reg) < MAX_ZONES)
                         && (mid_reg > rec_reg.zbegin)
                         && (mid_reg < rec_reg.zend);
        status.zone_empty = (rec_reg.zbegin == rec_reg.zend);
        status.has_prev   = curhas_prev_reg;
        status.pending    = pend_reg;
        status.out_free   = !ov_reg || out_ready;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            failed_reg <= read_error;
        case (cmd)
            CMD_CAPTURE:
            begin
                rec_reg <= rd_rec;
                len_reg <= rd_len;
            end
            CMD_SPLIT_MID:
            begin
                mid_reg <= (rec_reg.zbegin + (len_reg >> 1))
                           & ~LBA_W'(CHUNK_SECTORS - 1);
                nz_reg  <= alloc_slot;
            end
            CMD_SPLIT_HEAD:
            begin
                rec_reg.zend <= mid_reg;
                len_reg      <= mid_reg - rec_reg.zbegin;
            end
            CMD_REP_UPDATE:
            begin
                rec_reg <= upd_rec;
            end
            CMD_TAKE:
            begin
                res_secs_reg <= secs;
                res_lba_reg  <= rec_reg.bb ? rec_reg.zend - LBA_W'(secs) : rec_reg.zbegin;
            end
            CMD_TAKE_FWD:
            begin
                res_secs_reg <= secs;
                res_lba_reg  <= rec_reg.zbegin;
            end
            CMD_REQ_EMPTY, CMD_RES_ZERO:
            begin
                res_secs_reg <= '0;
                res_lba_reg  <= '0;
            end
            CMD_POST:
            begin
                ol_reg <= res_lba_reg;
                os_reg <= res_secs_reg;
                od_reg <= (count_reg == '0);
                oz_reg <= ZONES_OUT_W'(count_reg);
            end
            default:
            begin
                len_reg <= len_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg       <= '0;
            limit_reg       <= '0;
            smin_reg        <= SPLIT_MIN_RESET;
            head_reg        <= '0;
            count_reg       <= '0;
            curidx_reg      <= '0;
            curprev_reg     <= '0;
            curhas_prev_reg <= 1'b0;
            back_reg        <= 1'b0;
            pend_reg        <= 1'b0;
            tlen_reg        <= '0;
            cur_reg         <= '0;
            prev_reg        <= '0;
            has_prev_reg    <= 1'b0;
            n_reg           <= '0;
            sp_reg          <= '0;
            hwm_reg         <= '0;
            ov_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIRST_LBA: first_reg <= cfg_data;
                    CFG_LIMIT_LBA: limit_reg <= cfg_data;
                    CFG_SPLIT_MIN: smin_reg  <= cfg_data;
                    default:       smin_reg  <= smin_reg;
                endcase
            end
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            case (cmd)
                CMD_RESTART:
                begin
                    head_reg   <= '0;
                    count_reg  <= (limit_reg > first_reg) ? CW'(1) : '0;
                    hwm_reg    <= (limit_reg > first_reg) ? CW'(1) : '0;
                    sp_reg     <= '0;
                    curidx_reg <= '0;
                    back_reg   <= 1'b0;
                    pend_reg   <= 1'b0;
                    tlen_reg   <= '0;
                end
                CMD_REQ_EMPTY:
                begin
                    pend_reg <= 1'b0;
                end
                CMD_WALK_START, CMD_HEAD_READ:
                begin
                    cur_reg      <= head_reg;
                    has_prev_reg <= 1'b0;
                    n_reg        <= '0;
                end
                CMD_WALK_NEXT:
                begin
                    prev_reg     <= cur_reg;
                    has_prev_reg <= 1'b1;
                    cur_reg      <= rd_rec.znext;
                    n_reg        <= CW'(n_reg + 1'b1);
                end
                CMD_SPLIT_NEW:
                begin
                    // slot taken and zone counted in the same cycle
                    if (sp_reg != '0)
                        sp_reg <= CW'(sp_reg - 1'b1);
                    else
                        hwm_reg <= CW'(hwm_reg + 1'b1);
                    count_reg <= CW'(count_reg + 1'b1);
                end
                CMD_TAKE, CMD_TAKE_FWD:
                begin
                    curidx_reg      <= cur_reg;
                    curprev_reg     <= prev_reg;
                    curhas_prev_reg <= has_prev_reg;
                    back_reg        <= (cmd == CMD_TAKE) ? rec_reg.bb : 1'b0;
                    pend_reg        <= 1'b1;
                    tlen_reg        <= secs;
                end
                CMD_REP_UPDATE:
                begin
                    pend_reg <= 1'b0;
                end
                CMD_UNLINK_PREV, CMD_UNLINK_HEAD:
                begin
                    if (cmd == CMD_UNLINK_HEAD)
                        head_reg <= rec_reg.znext;
                    count_reg <= CW'(count_reg - 1'b1);
                    sp_reg    <= CW'(sp_reg + 1'b1);
                end
                CMD_POST:
                begin
                    ov_reg <= 1'b1;
                end
                default:
                begin
                    back_reg <= back_reg;
                end
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign out_lba   = ol_reg;
    assign out_secs  = os_reg;
    assign out_done  = od_reg;
    assign out_zones = oz_reg;

    `DMRS_ASSERT_NOW(a_slot_balance, 1'b1, CW'(count_reg + sp_reg) == hwm_reg,
        "zone count and free slots disagree")
    `DMRS_ASSERT_NOW(a_pend_nonempty, pend_reg, count_reg != '0,
        "pending task on empty table")
    `DMRS_ASSERT_NEXT(a_split_grows, cmd == CMD_SPLIT_NEW,
        count_reg == CW'($past(count_reg) + 1'b1), "split did not add a zone")

endmodule

/* rtl/damaged_media_read_scheduler.sv */
// top level of the damaged media read scheduler
`timescale 1ns / 1ps
// Schedules reads over a table of unread sector zones on damaged media.
// in_ch carries one request: opcode (0 next task, 1 report outcome, 2 restart)
// and read_error for reports. out_ch returns exactly one result per request:
// task_lba, task_sectors, all_done and zones_in_use.
// Configuration (first_lba, limit_lba, split_min_length) is written through
// cfg_we / cfg_index / cfg_data; the user must write it only while no request
// is in flight, as the block does not enforce this. A task request walks the
// zone list from the head, one zone at a time over the single read port of
// the zone table, to the first zone not bad at both ends. When every zone is
// bad at both ends the head zone is reread and may be split. A request on an
// empty table goes straight to posting; a report reads its zone, updates it
// and, if the zone is now empty, unlinks it, through the zone before it when
// there is one; a stray report, a restart or opcode 3 post a zeroed result.
// One request is in flight at a time; the next is taken the cycle after the
// result is posted. Reset empties the table and loads split_min_length with
// 1000000. The result sits in an output register; while the receiver stalls
// it is held, one more request may be worked off and waits to post, and no
// further request is taken.
module damaged_media_read_scheduler #(
    parameter int MAX_ZONES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dmrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmrs_pkg::LBA_W-1:0]     cfg_data,
    dmrs_in_if.sink                        in_ch,
    dmrs_out_if.source                     out_ch
);
    import dmrs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    assign in_ch.ready = in_ready;

    // controller
    dmrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    dmrs_datapath #(
        .MAX_ZONES (MAX_ZONES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (in_ch.valid && in_ready),
        .read_error  (in_ch.read_error),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_lba     (out_ch.task_lba),
        .out_secs    (out_ch.task_sectors),
        .out_done    (out_ch.all_done),
        .out_zones   (out_ch.zones_in_use)
    );

endmodule
